>>> hw/rtl/klc_pkg.sv
// Shared types, constants and command/status structs for the knob lamp controller.
// No dependencies; every other file imports this package.
package klc_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int DIVISOR_BITS   = 7;
  localparam int VALUE_BITS     = 9;

  localparam logic [VALUE_BITS-1:0] BRIGHT_TOP   = 9'd255;
  localparam logic [VALUE_BITS-1:0] HUE_TOP      = 9'd359;
  localparam logic [VALUE_BITS-1:0] HUE_SECTOR   = 9'd60;
  localparam logic [7:0]            BRIGHT_RESET = 8'd128;
  localparam logic [15:0]           TIMER_MAX    = 16'hFFFF;

  localparam logic [9:0]  DEBOUNCE_RESET   = 10'd30;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd600;
  localparam logic [2:0]  CPN_RESET        = 3'd4;
  localparam logic [6:0]  BSTEP_RESET      = 7'd5;
  localparam logic [5:0]  HSTEP_RESET      = 6'd5;
  localparam int          KNOB_RESET       = (128 / 5) * 4;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_DEBOUNCE   = 3'd0,
    CFG_LONG_PRESS = 3'd1,
    CFG_CPN        = 3'd2,
    CFG_INVERT     = 3'd3,
    CFG_BSTEP      = 3'd4,
    CFG_HSTEP      = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    DIV_SYNC  = 2'd0,
    DIV_NOTCH = 2'd1,
    DIV_TOP   = 2'd2
  } div_op_t;

  typedef struct packed {
    logic              button_level;
    logic signed [3:0] count_change;
  } item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] level;
    logic       power_on;
    logic       hue_mode;
    logic       refresh;
  } result_t;

  typedef struct packed {
    logic    accept;
    logic    div_start;
    div_op_t div_op;
    logic    sync_anchor;
    logic    eval;
    logic    top_anchor;
    logic    load;
  } cmd_t;

  typedef struct packed {
    logic need_sync;
    logic need_top;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

>>> hw/rtl/klc_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, unsigned.
// Depends on klc_pkg for the divisor width.
module klc_div import klc_pkg::*; #(
  parameter int DW = COUNT_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [DW-1:0]           dividend,
  input  logic [DIVISOR_BITS-1:0] divisor,
  output logic                    busy,
  output logic [DW-1:0]           quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0]           cnt;
  logic [DIVISOR_BITS-1:0] rem;
  logic [DIVISOR_BITS-1:0] dsr;
  logic [DW-1:0]           quo;
  logic [DIVISOR_BITS:0]   trial;
  logic                    fits;

  assign trial    = {rem, quo[DW-1]};
  assign fits     = trial >= {1'b0, dsr};
  assign busy     = cnt != '0;
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(DW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DIVISOR_BITS'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[DIVISOR_BITS-1:0];
      end
      quo <= {quo[DW-2:0], fits};
    end
  end

endmodule

>>> hw/rtl/klc_datapath.sv
// Datapath: registers, knob count, debounce, notch evaluation, color and result register.
// Depends on klc_pkg and klc_div; driven by klc_ctrl through cmd_t / status_t.
module klc_datapath import klc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output status_t                   status,
  input  item_t                     item,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output logic                      result_valid,
  input  logic                      result_stall,
  output result_t                   result
);

  localparam int AW = COUNT_BITS + 12;
  localparam logic signed [COUNT_BITS-1:0] KNOB_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] KNOB_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
  localparam logic [AW-1:0] KNOB_MAX_W = {13'd0, {(COUNT_BITS-1){1'b1}}};

  logic [9:0]  debounce_limit;
  logic [15:0] long_press_limit;
  logic [2:0]  counts_per_notch;
  logic        invert_direction;
  logic [6:0]  bright_step;
  logic [5:0]  hue_step;

  logic signed [COUNT_BITS-1:0] knob_count;
  logic        last_level;
  logic [15:0] stable_ticks;
  logic        pressed;
  logic [15:0] press_ticks;
  logic        mode_flag;
  logic        lamp_on;
  logic [8:0]  hue_value;
  logic [7:0]  bright_value;
  logic        refresh;
  logic        need_sync;
  logic        need_top;
  logic        x_neg;

  logic [2:0]              cpn_eff;
  logic [DIVISOR_BITS-1:0] bstep_eff;
  logic [DIVISOR_BITS-1:0] hstep_eff;
  logic [DIVISOR_BITS-1:0] step_eff;
  logic [8:0]              top;

  logic [COUNT_BITS-1:0]     div_dividend;
  logic [DIVISOR_BITS-1:0]   div_divisor;
  logic                      div_busy;
  logic [COUNT_BITS-1:0]     div_quotient;

  logic signed [COUNT_BITS:0]   sum;
  logic signed [COUNT_BITS-1:0] count_sat;
  logic [15:0] press_next;
  logic [15:0] stable_next;
  logic        level_changed;
  logic        is_stable;
  logic        do_press;
  logic        do_release;
  logic        long_hit;

  logic [COUNT_BITS-1:0] knob_bits;
  logic [COUNT_BITS-1:0] knob_mag;
  logic                  knob_xneg;

  logic [15:0] prod;
  logic [8:0]  raw;
  logic        clamp_zero;
  logic        clamp_top;

  logic [7:0] hr;
  logic [7:0] hg;
  logic [7:0] hb;

  function automatic logic signed [COUNT_BITS-1:0] anchor_count(
    input logic [8:0] n,
    input logic [2:0] cpn,
    input logic       inv
  );
    logic [11:0] p;
    logic signed [COUNT_BITS-1:0] r;
    p = 12'(n) * 12'(cpn);
    if (AW'(p) > KNOB_MAX_W) begin
      r = inv ? KNOB_MIN : KNOB_MAX;
    end else begin
      r = inv ? -COUNT_BITS'(p) : COUNT_BITS'(p);
    end
    return r;
  endfunction

  function automatic logic [23:0] hue_to_rgb(input logic [8:0] h);
    logic [2:0]  region;
    logic [8:0]  base;
    logic [5:0]  rem6;
    logic [9:0]  scaled;
    logic [7:0]  t;
    logic [7:0]  q;
    logic [23:0] rgb;
    if (h >= 9'(HUE_SECTOR * 5)) begin
      region = 3'd5; base = 9'(HUE_SECTOR * 5);
    end else if (h >= 9'(HUE_SECTOR * 4)) begin
      region = 3'd4; base = 9'(HUE_SECTOR * 4);
    end else if (h >= 9'(HUE_SECTOR * 3)) begin
      region = 3'd3; base = 9'(HUE_SECTOR * 3);
    end else if (h >= 9'(HUE_SECTOR * 2)) begin
      region = 3'd2; base = 9'(HUE_SECTOR * 2);
    end else if (h >= HUE_SECTOR) begin
      region = 3'd1; base = HUE_SECTOR;
    end else begin
      region = 3'd0; base = 9'd0;
    end
    rem6   = 6'(h - base);
    scaled = 10'(rem6) * 10'd17;
    t      = 8'(scaled >> 2);
    q      = 8'd255 - t;
    case (region)
      3'd1:    rgb = {q, 8'd255, 8'd0};
      3'd2:    rgb = {8'd0, 8'd255, t};
      3'd3:    rgb = {8'd0, q, 8'd255};
      3'd4:    rgb = {t, 8'd0, 8'd255};
      3'd5:    rgb = {8'd255, 8'd0, q};
      default: rgb = {8'd255, t, 8'd0};
    endcase
    return rgb;
  endfunction

  assign cpn_eff   = (counts_per_notch == 3'd0) ? 3'd1 : counts_per_notch;
  assign bstep_eff = (bright_step == 7'd0) ? 7'd1 : bright_step;
  assign hstep_eff = (hue_step == 6'd0) ? 7'd1 : DIVISOR_BITS'(hue_step);
  assign step_eff  = mode_flag ? hstep_eff : bstep_eff;
  assign top       = mode_flag ? HUE_TOP : BRIGHT_TOP;

  always_comb begin
    sum = (COUNT_BITS+1)'(knob_count) + (COUNT_BITS+1)'(item.count_change);
    if (sum > (COUNT_BITS+1)'(KNOB_MAX)) begin
      count_sat = KNOB_MAX;
    end else if (sum < (COUNT_BITS+1)'(KNOB_MIN)) begin
      count_sat = KNOB_MIN;
    end else begin
      count_sat = COUNT_BITS'(sum);
    end

    press_next = (pressed && press_ticks < TIMER_MAX) ? press_ticks + 16'd1 : press_ticks;

    level_changed = item.button_level != last_level;
    if (level_changed) begin
      stable_next = 16'd0;
    end else if (stable_ticks < TIMER_MAX) begin
      stable_next = stable_ticks + 16'd1;
    end else begin
      stable_next = stable_ticks;
    end

    is_stable  = stable_next > 16'(debounce_limit);
    do_press   = is_stable && !pressed && !item.button_level;
    do_release = is_stable && pressed && item.button_level;
    long_hit   = press_next >= long_press_limit;
  end

  always_comb begin
    knob_bits = knob_count;
    knob_mag  = knob_bits[COUNT_BITS-1] ? (~knob_bits + COUNT_BITS'(1)) : knob_bits;
    knob_xneg = invert_direction ? (!knob_bits[COUNT_BITS-1] && knob_bits != '0)
                                 : knob_bits[COUNT_BITS-1];
  end

  always_comb begin
    case (cmd.div_op)
      DIV_SYNC: begin
        div_dividend = mode_flag ? COUNT_BITS'(hue_value) : COUNT_BITS'(bright_value);
        div_divisor  = step_eff;
      end
      DIV_NOTCH: begin
        div_dividend = knob_mag;
        div_divisor  = DIVISOR_BITS'(cpn_eff);
      end
      DIV_TOP: begin
        div_dividend = COUNT_BITS'(top);
        div_divisor  = step_eff;
      end
      default: begin
        div_dividend = knob_mag;
        div_divisor  = DIVISOR_BITS'(cpn_eff);
      end
    endcase
  end

  klc_div #(.DW(COUNT_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  always_comb begin
    prod       = 16'(div_quotient[8:0]) * 16'(step_eff);
    clamp_zero = x_neg && div_quotient != '0;
    clamp_top  = 1'b0;
    raw        = 9'd0;
    if (clamp_zero) begin
      raw = 9'd0;
    end else if (div_quotient > COUNT_BITS'(top) || prod > 16'(top)) begin
      raw       = top;
      clamp_top = 1'b1;
    end else if (x_neg) begin
      raw = 9'd0;
    end else begin
      raw = prod[8:0];
    end
  end

  assign {hr, hg, hb} = hue_to_rgb(hue_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_limit   <= DEBOUNCE_RESET;
      long_press_limit <= LONG_PRESS_RESET;
      counts_per_notch <= CPN_RESET;
      invert_direction <= 1'b0;
      bright_step      <= BSTEP_RESET;
      hue_step         <= HSTEP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEBOUNCE:   debounce_limit   <= cfg_data[9:0];
        CFG_LONG_PRESS: long_press_limit <= cfg_data[15:0];
        CFG_CPN:        counts_per_notch <= cfg_data[2:0];
        CFG_INVERT:     invert_direction <= cfg_data[0];
        CFG_BSTEP:      bright_step      <= cfg_data[6:0];
        CFG_HSTEP:      hue_step         <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      knob_count   <= COUNT_BITS'(KNOB_RESET);
      last_level   <= 1'b1;
      stable_ticks <= 16'd0;
      pressed      <= 1'b0;
      press_ticks  <= 16'd0;
      mode_flag    <= 1'b0;
      lamp_on      <= 1'b1;
      hue_value    <= 9'd0;
      bright_value <= BRIGHT_RESET;
      refresh      <= 1'b0;
      need_sync    <= 1'b0;
      need_top     <= 1'b0;
      x_neg        <= 1'b0;
    end else begin
      if (cmd.accept) begin
        knob_count   <= count_sat;
        stable_ticks <= stable_next;
        last_level   <= item.button_level;
        press_ticks  <= do_press ? 16'd0 : press_next;
        refresh      <= do_release && long_hit;
        need_sync    <= do_release && !long_hit;
        if (do_press) begin
          pressed <= 1'b1;
        end else if (do_release) begin
          pressed <= 1'b0;
          if (long_hit) begin
            lamp_on <= ~lamp_on;
          end else begin
            mode_flag <= ~mode_flag;
          end
        end
      end
      if (cmd.div_start && cmd.div_op == DIV_NOTCH) begin
        x_neg <= knob_xneg;
      end
      if (cmd.sync_anchor || cmd.top_anchor) begin
        knob_count <= anchor_count(div_quotient[8:0], cpn_eff, invert_direction);
      end
      if (cmd.eval) begin
        need_top <= clamp_top;
        if (clamp_zero) begin
          knob_count <= '0;
        end
        if (mode_flag) begin
          if (raw != hue_value) begin
            hue_value <= raw;
            refresh   <= 1'b1;
          end
        end else begin
          if (raw[7:0] != bright_value) begin
            bright_value <= raw[7:0];
            refresh      <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result.red      <= lamp_on ? hr : 8'd0;
      result.green    <= lamp_on ? hg : 8'd0;
      result.blue     <= lamp_on ? hb : 8'd0;
      result.level    <= lamp_on ? bright_value : 8'd0;
      result.power_on <= lamp_on;
      result.hue_mode <= mode_flag;
      result.refresh  <= refresh;
    end
  end

  assign status.need_sync = need_sync;
  assign status.need_top  = need_top;
  assign status.div_busy  = div_busy;
  assign status.out_free  = !result_valid || !result_stall;

endmodule

>>> hw/rtl/klc_ctrl.sv
// Controller state machine: sequences one tick through sync, notch and clamp steps.
// Depends on klc_pkg for cmd_t and status_t.
module klc_ctrl import klc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [7:0] {
    ST_IDLE        = 8'b00000001,
    ST_BRANCH      = 8'b00000010,
    ST_SYNC_WAIT   = 8'b00000100,
    ST_NOTCH_START = 8'b00001000,
    ST_NOTCH_WAIT  = 8'b00010000,
    ST_TOP_CHECK   = 8'b00100000,
    ST_TOP_WAIT    = 8'b01000000,
    ST_FINISH      = 8'b10000000
  } state_t;

  state_t state;
  state_t state_next;

  assign item_stall = state != ST_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_op = DIV_NOTCH;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_BRANCH;
        end
      end
      ST_BRANCH: begin
        cmd.div_start = 1'b1;
        if (status.need_sync) begin
          cmd.div_op = DIV_SYNC;
          state_next = ST_SYNC_WAIT;
        end else begin
          state_next = ST_NOTCH_WAIT;
        end
      end
      ST_SYNC_WAIT: begin
        if (!status.div_busy) begin
          cmd.sync_anchor = 1'b1;
          state_next      = ST_NOTCH_START;
        end
      end
      ST_NOTCH_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_NOTCH_WAIT;
      end
      ST_NOTCH_WAIT: begin
        if (!status.div_busy) begin
          cmd.eval   = 1'b1;
          state_next = ST_TOP_CHECK;
        end
      end
      ST_TOP_CHECK: begin
        if (status.need_top) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DIV_TOP;
          state_next    = ST_TOP_WAIT;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_TOP_WAIT: begin
        cmd.div_op = DIV_TOP;
        if (!status.div_busy) begin
          cmd.top_anchor = 1'b1;
          state_next     = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hw/rtl/knob_lamp_controller.sv
// Knob lamp controller top level: controller, datapath and port handshakes.
// One item at a time: each item runs a notch divide, preceded by a mode sync divide after a
// short press and followed by a clamp re-anchor divide when the value clamps at its top.
// All divides are bit-serial; the result is registered and loaded at the end of each item;
// the next item is taken while the result waits, a stalled result holds the last step.
// Synchronous active-high reset: registers at defaults, knob count synced to brightness 128.
module knob_lamp_controller import klc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  item_t                     item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output result_t                   result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  klc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  klc_datapath #(.COUNT_BITS(COUNT_BITS)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item         (item),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!result_valid || !result_stall))
    else $error("result loaded over a waiting item");

  assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.div_busy)
    else $error("divider restarted while busy");

  assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("item accepted while previous item still in work");

  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.div_start, cmd.sync_anchor, cmd.eval, cmd.top_anchor, cmd.load}))
    else $error("more than one datapath command in a cycle");

endmodule
